>>> rtl/npse_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the nearest point search block
// no dependencies
package npse_pkg;

  localparam int TURN_W = 26;
  localparam logic [TURN_W-1:0] TURN_RESET = 26'd400;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_D_FIRST,
    ST_D_LAST,
    ST_D_QUERY,
    ST_EVAL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } mem_ctl_t;

endpackage

>>> rtl/npse_point_mem.sv
`timescale 1ns / 1ps
// point store: one write port, one read port with registered read data
// uses npse_pkg
module npse_point_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 24
) (
  input  logic                clk,
  input  npse_pkg::mem_ctl_t  ctl,
  input  logic [AW-1:0]       waddr,
  input  logic [DW-1:0]       wdata,
  input  logic [AW-1:0]       raddr,
  output logic [DW-1:0]       rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/npse_sq_dist.sv
`timescale 1ns / 1ps
// shared squared euclidean distance unit, result registered
// no dependencies
module npse_sq_dist #(
  parameter int CW = 12
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] ax,
  input  logic signed [CW-1:0] ay,
  input  logic signed [CW-1:0] bx,
  input  logic signed [CW-1:0] by,
  output logic [2*CW+2:0]      sq_sum
);

  logic signed [CW:0]     dx;
  logic signed [CW:0]     dy;
  logic signed [2*CW+1:0] sx;
  logic signed [2*CW+1:0] sy;
  logic [2*CW+2:0]        dist_next;

  assign dx = {ax[CW-1], ax} - {bx[CW-1], bx};
  assign dy = {ay[CW-1], ay} - {by[CW-1], by};
  assign sx = dx * dx;
  assign sy = dy * dy;
  assign dist_next = {1'b0, $unsigned(sx)} + {1'b0, $unsigned(sy)};

  always_ff @(posedge clk) begin
    sq_sum <= dist_next;
  end

endmodule

>>> rtl/nearest_point_search_excluding_ends.sv
`timescale 1ns / 1ps
// Nearest point search over a stored list of up to MAX_POINTS points. Append
// and clear are handled in the idle state. In a query on a list of n points,
// every point after the first is read once from the point store and passes
// three times through the shared squared-distance unit (against the first
// point, the last point and the query position). Results leave through an
// output register, so the next beat is taken while a result waits. turn_distance must be
// written on the cfg port only while the block is idle; the block itself does not enforce this.
// uses npse_pkg, npse_point_mem, npse_sq_dist
module nearest_point_search_excluding_ends #(
  parameter int MAX_POINTS = 256,
  parameter int COORD_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,  // pos_x, pos_y
  input  logic [1:0]              s_tuser,   // command
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,  // nearest_x, nearest_y
  output logic [1:0]              m_tuser,   // found, overflow
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [npse_pkg::TURN_W-1:0] cfg_data
);

  localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW   = $clog2(MAX_POINTS + 1);
  localparam int PW   = 2 * COORD_BITS;
  localparam int DW   = 2 * COORD_BITS + 3;
  localparam int TW   = npse_pkg::TURN_W;
  localparam int KW   = (DW > TW) ? DW : TW;
  localparam int BW   = ((2 * COORD_BITS + 7) / 8) * 8;

  npse_pkg::state_t state, state_next;
  npse_pkg::mem_ctl_t mem_ctl;

  logic [TW-1:0]          turn;
  logic [NW-1:0]          count;
  logic [AW-1:0]          idx;
  logic [AW-1:0]          raddr;
  logic [PW-1:0]          rdata;
  logic [DW-1:0]          sq_sum;
  logic [DW-1:0]          best;
  logic                   have;
  logic                   ok_first;
  logic                   ok_last;
  logic                   dist_over;
  logic                   s_beat;
  logic                   out_free;
  logic                   last_point;

  logic signed [COORD_BITS-1:0] in_x, in_y;
  logic signed [COORD_BITS-1:0] cur_x, cur_y;
  logic signed [COORD_BITS-1:0] first_x, first_y;
  logic signed [COORD_BITS-1:0] last_x, last_y;
  logic signed [COORD_BITS-1:0] qry_x, qry_y;
  logic signed [COORD_BITS-1:0] res_x, res_y;
  logic signed [COORD_BITS-1:0] op_x, op_y;
  logic                         res_found;
  logic                         res_ovf;

  assign in_x   = s_tdata[COORD_BITS-1:0];
  assign in_y   = s_tdata[PW-1:COORD_BITS];
  assign cur_x  = rdata[COORD_BITS-1:0];
  assign cur_y  = rdata[PW-1:COORD_BITS];
  assign s_beat = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign dist_over = KW'(sq_sum) > KW'(turn);
  assign last_point = NW'(idx) == (count - NW'(1));

  npse_point_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW),
    .DW    (PW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (count[AW-1:0]),
    .wdata ({in_y, in_x}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    case (state)
      npse_pkg::ST_D_FIRST: begin
        op_x = first_x;
        op_y = first_y;
      end
      npse_pkg::ST_D_LAST: begin
        op_x = last_x;
        op_y = last_y;
      end
      default: begin
        op_x = qry_x;
        op_y = qry_y;
      end
    endcase
  end

  npse_sq_dist #(
    .CW (COORD_BITS)
  ) u_dist (
    .clk    (clk),
    .ax     (op_x),
    .ay     (op_y),
    .bx     (cur_x),
    .by     (cur_y),
    .sq_sum (sq_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= npse_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_ctl    = '0;
    raddr      = idx;
    unique case (state)
      npse_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (npse_pkg::cmd_t'(s_tuser))
            npse_pkg::CMD_APPEND: begin
              if (count < NW'(MAX_POINTS)) begin
                mem_ctl.wr = 1'b1;
              end else begin
                state_next = npse_pkg::ST_OUT;
              end
            end
            npse_pkg::CMD_QUERY: begin
              if (count > NW'(1)) begin
                state_next = npse_pkg::ST_READ;
              end else begin
                state_next = npse_pkg::ST_OUT;
              end
            end
            default: state_next = npse_pkg::ST_IDLE;
          endcase
        end
      end
      npse_pkg::ST_READ: begin
        mem_ctl.rd = 1'b1;
        state_next = npse_pkg::ST_D_FIRST;
      end
      npse_pkg::ST_D_FIRST: state_next = npse_pkg::ST_D_LAST;
      npse_pkg::ST_D_LAST:  state_next = npse_pkg::ST_D_QUERY;
      npse_pkg::ST_D_QUERY: state_next = npse_pkg::ST_EVAL;
      npse_pkg::ST_EVAL: begin
        if (last_point) begin
          state_next = npse_pkg::ST_OUT;
        end else begin
          mem_ctl.rd = 1'b1;
          raddr      = idx + AW'(1);
          state_next = npse_pkg::ST_D_FIRST;
        end
      end
      npse_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = npse_pkg::ST_IDLE;
        end
      end
      default: state_next = npse_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      turn  <= npse_pkg::TURN_RESET;
      count <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        turn <= cfg_data;
      end
      if (s_beat && npse_pkg::cmd_t'(s_tuser) == npse_pkg::CMD_APPEND &&
          count < NW'(MAX_POINTS)) begin
        count <= count + NW'(1);
      end else if (s_beat && npse_pkg::cmd_t'(s_tuser) == npse_pkg::CMD_CLEAR) begin
        count <= '0;
      end
    end
  end

  // query datapath and list end points
  always_ff @(posedge clk) begin
    if (s_beat) begin
      unique case (npse_pkg::cmd_t'(s_tuser))
        npse_pkg::CMD_APPEND: begin
          if (count < NW'(MAX_POINTS)) begin
            if (count == '0) begin
              first_x <= in_x;
              first_y <= in_y;
            end
            last_x <= in_x;
            last_y <= in_y;
          end
          res_x     <= '0;
          res_y     <= '0;
          res_found <= 1'b0;
          res_ovf   <= 1'b1;
        end
        npse_pkg::CMD_QUERY: begin
          qry_x     <= in_x;
          qry_y     <= in_y;
          idx       <= AW'(1);
          have      <= 1'b0;
          res_ovf   <= 1'b0;
          res_found <= count != '0;
          res_x     <= (count != '0) ? first_x : '0;
          res_y     <= (count != '0) ? first_y : '0;
        end
        default: begin
        end
      endcase
    end
    if (state == npse_pkg::ST_D_LAST) begin
      ok_first <= dist_over;
    end
    if (state == npse_pkg::ST_D_QUERY) begin
      ok_last <= dist_over;
    end
    if (state == npse_pkg::ST_EVAL) begin
      if (ok_first && ok_last && (!have || sq_sum < best)) begin
        best  <= sq_sum;
        have  <= 1'b1;
        res_x <= cur_x;
        res_y <= cur_y;
      end
      idx <= idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == npse_pkg::ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == npse_pkg::ST_OUT && out_free) begin
      m_tdata <= BW'({res_y, res_x});
      m_tuser <= {res_ovf, res_found};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(MAX_POINTS))
    else $error("stored point count beyond store depth");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("found and overflow set on the same beat");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == npse_pkg::ST_EVAL |-> (idx != '0 && NW'(idx) < count))
    else $error("scan index outside stored points");

  a_read_before_dist: assert property (@(posedge clk) disable iff (rst)
    (state == npse_pkg::ST_D_FIRST) |->
      ($past(state) == npse_pkg::ST_READ || $past(state) == npse_pkg::ST_EVAL))
    else $error("distance pass started without a point read");

endmodule

>>> test/npse_result_check.sv
`timescale 1ns / 1ps
// result checker for nearest_point_search_excluding_ends: mirrors the point list and
// turn distance from the beats it sees, predicts every result and compares it
// uses npse_pkg; instantiated by nearest_point_search_excluding_ends_tb
module npse_result_check #(
  parameter int MAX_POINTS = 256,
  parameter int COORD_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  input  logic                                  s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,   // pos_x, pos_y
  input  logic [1:0]                            s_tuser,   // command
  input  logic                                  m_tvalid,
  input  logic                                  m_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,   // nearest_x, nearest_y
  input  logic [1:0]                            m_tuser,   // found, overflow
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [npse_pkg::TURN_W-1:0]           cfg_data,
  output int                                    fail_count,
  output int                                    pending
);

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  found;
    logic                  overflow;
  } nearest_t;

  logic signed [COORD_BITS-1:0] list_x [MAX_POINTS];
  logic signed [COORD_BITS-1:0] list_y [MAX_POINTS];
  int unsigned                  list_len;
  logic [npse_pkg::TURN_W-1:0]  turn_dist;
  nearest_t                     answer_q [$];
  nearest_t                     got;
  nearest_t                     want;
  int                           bad_beats = 0;

  function automatic longint sq_gap(int ax, int ay, int bx, int by);
    longint dx;
    longint dy;
    dx = ax - bx;
    dy = ay - by;
    return dx * dx + dy * dy;
  endfunction

  function automatic nearest_t nearest_of(int px, int py);
    nearest_t r;
    int       last;
    longint   limit;
    longint   best;
    longint   d;
    bit       have;
    r = '0;
    if (list_len == 0) return r;
    last  = list_len - 1;
    limit = turn_dist;
    have  = 1'b0;
    best  = 0;
    r.x = list_x[0];
    r.y = list_y[0];
    r.found = 1'b1;
    for (int i = 1; i < list_len; i++) begin
      if (sq_gap(list_x[0], list_y[0], list_x[i], list_y[i]) > limit &&
          sq_gap(list_x[last], list_y[last], list_x[i], list_y[i]) > limit) begin
        d = sq_gap(list_x[i], list_y[i], px, py);
        // equal distance keeps the earlier point
        if (!have || d < best) begin
          best = d;
          r.x  = list_x[i];
          r.y  = list_y[i];
          have = 1'b1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      list_len  = 0;
      turn_dist = npse_pkg::TURN_RESET;
      answer_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.x        = m_tdata[COORD_BITS-1:0];
        got.y        = m_tdata[2*COORD_BITS-1:COORD_BITS];
        got.found    = m_tuser[0];
        got.overflow = m_tuser[1];
        if (answer_q.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("unexpected result beat: x=%0d y=%0d found=%0b overflow=%0b",
                     $signed(got.x), $signed(got.y), got.found, got.overflow);
        end else begin
          want = answer_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.found !== want.found ||
              got.overflow !== want.overflow) begin
            bad_beats++;
            if (bad_beats <= 10)
              $display("mismatch: expected x=%0d y=%0d found=%0b overflow=%0b, got %s",
                       $signed(want.x), $signed(want.y), want.found, want.overflow,
                       $sformatf("x=%0d y=%0d found=%0b overflow=%0b", $signed(got.x),
                                 $signed(got.y), got.found, got.overflow));
          end
        end
      end
      if (cfg_valid && cfg_ready) turn_dist = cfg_data;
      if (s_tvalid && s_tready) begin
        case (npse_pkg::cmd_t'(s_tuser))
          npse_pkg::CMD_APPEND: begin
            if (list_len < MAX_POINTS) begin
              list_x[list_len] = s_tdata[COORD_BITS-1:0];
              list_y[list_len] = s_tdata[2*COORD_BITS-1:COORD_BITS];
              list_len++;
            end else begin
              want = '0;
              want.overflow = 1'b1;
              answer_q.push_back(want);
            end
          end
          npse_pkg::CMD_CLEAR: list_len = 0;
          npse_pkg::CMD_QUERY: answer_q.push_back(
                                 nearest_of($signed(s_tdata[COORD_BITS-1:0]),
                                            $signed(s_tdata[2*COORD_BITS-1:COORD_BITS])));
          default: ;
        endcase
      end
      fail_count <= bad_beats;
      pending    <= answer_q.size();
    end
  end

endmodule

>>> test/nearest_point_search_excluding_ends_tb.sv
`timescale 1ns / 1ps
// testbench top for nearest_point_search_excluding_ends: drives point commands and
// turn distance writes with random flow control, the checker gives the verdict count
// uses npse_pkg, npse_result_check and the block under test
module nearest_point_search_excluding_ends_tb;

  localparam int LIMIT_CYCLES = 2_000_000;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [23:0]                 s_tdata = '0;   // pos_x, pos_y
  logic [1:0]                  s_tuser = '0;   // command
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [23:0]                 m_tdata;        // nearest_x, nearest_y
  logic [1:0]                  m_tuser;        // found, overflow
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [npse_pkg::TURN_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int items_sent = 0;
  int burst_left = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int ready_mode = 0;
  int mode_left = 0;

  nearest_point_search_excluding_ends dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  npse_result_check result_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    for (int cycles = 0; cycles < LIMIT_CYCLES; cycles++) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // result side: long hold-off on request, otherwise changing stall patterns
  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      case (ready_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 1);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (mode_left % 3 != 0);
      endcase
    end
  end

  function automatic logic [11:0] rand_coord();
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic logic [11:0] near(int c, int spread);
    int v;
    v = c + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < -2048) v = -2048;
    if (v > 2047) v = 2047;
    return v[11:0];
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_beat(input npse_pkg::cmd_t c, input logic [11:0] x,
                           input logic [11:0] y);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= {y, x};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (c != npse_pkg::CMD_NONE) items_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_turn(input logic [npse_pkg::TURN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly a clear, then scattered points, a short stroke or a cloud of points, then a few lookups
  task automatic run_sequence();
    int          n_add;
    int          n_ask;
    int          style;
    int          cx;
    int          cy;
    logic [11:0] px;
    logic [11:0] py;
    if ($urandom_range(0, 4) != 0) send_beat(npse_pkg::CMD_CLEAR, rand_coord(), rand_coord());
    n_add = $urandom_range(0, 12);
    style = $urandom_range(0, 2);
    cx = $signed(rand_coord());
    cy = $signed(rand_coord());
    for (int i = 0; i < n_add; i++) begin
      case (style)
        0: begin
          px = rand_coord();
          py = rand_coord();
        end
        1: begin
          px = near(cx, 40);
          py = near(cy, 40);
        end
        default: begin
          cx = $signed(near(cx, 30));
          cy = $signed(near(cy, 30));
          px = cx[11:0];
          py = cy[11:0];
        end
      endcase
      if ($urandom_range(0, 9) == 0) send_beat(npse_pkg::CMD_NONE, rand_coord(), rand_coord());
      send_beat(npse_pkg::CMD_APPEND, px, py);
    end
    n_ask = $urandom_range(1, 3);
    for (int i = 0; i < n_ask; i++) begin
      if (style == 0) send_beat(npse_pkg::CMD_QUERY, rand_coord(), rand_coord());
      else send_beat(npse_pkg::CMD_QUERY, near(cx, 60), near(cy, 60));
    end
  endtask

  initial begin
    logic [npse_pkg::TURN_W-1:0] turn_plan [7];
    int                          phase_end;
    turn_plan[0] = '0;
    turn_plan[1] = '1;
    turn_plan[2] = 26'($urandom_range(0, 67108863));
    turn_plan[3] = 26'd400;
    turn_plan[4] = 26'd2500;
    turn_plan[5] = 26'($urandom_range(0, 20000));
    turn_plan[6] = 26'd1000000;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at the reset turn distance
    send_beat(npse_pkg::CMD_QUERY, 12'd0, 12'd0);
    send_beat(npse_pkg::CMD_NONE, 12'hfff, 12'hfff);
    send_beat(npse_pkg::CMD_APPEND, 12'h800, 12'h800);
    send_beat(npse_pkg::CMD_QUERY, 12'h7ff, 12'h7ff);
    send_beat(npse_pkg::CMD_APPEND, 12'h7ff, 12'h7ff);
    send_beat(npse_pkg::CMD_QUERY, 12'd0, 12'd0);
    send_beat(npse_pkg::CMD_APPEND, 12'd5, 12'd0);
    send_beat(npse_pkg::CMD_APPEND, -12'sd5, 12'd0);
    send_beat(npse_pkg::CMD_APPEND, 12'd100, 12'd100);
    send_beat(npse_pkg::CMD_QUERY, 12'd0, 12'd0);
    send_beat(npse_pkg::CMD_APPEND, 12'd110, 12'd100);
    send_beat(npse_pkg::CMD_QUERY, 12'd100, 12'd100);
    send_beat(npse_pkg::CMD_QUERY, 12'h800, 12'h7ff);
    send_beat(npse_pkg::CMD_QUERY, 12'h7ff, 12'h800);
    send_beat(npse_pkg::CMD_APPEND, 12'h800, 12'h7ff);
    send_beat(npse_pkg::CMD_QUERY, 12'hfff, 12'hfff);
    send_beat(npse_pkg::CMD_CLEAR, 12'd0, 12'd0);
    send_beat(npse_pkg::CMD_QUERY, 12'd0, 12'd0);
    send_beat(npse_pkg::CMD_APPEND, 12'd0, 12'd0);
    send_beat(npse_pkg::CMD_APPEND, 12'd0, 12'd0);
    send_beat(npse_pkg::CMD_QUERY, 12'd0, 12'd0);
    send_beat(npse_pkg::CMD_CLEAR, 12'hfff, 12'hfff);

    for (int p = 0; p < 7; p++) begin
      wait_idle();
      write_turn(turn_plan[p]);
      phase_end = items_sent + 52;
      if (p == 2) begin
        // fill the store, overflow it, search it full
        send_beat(npse_pkg::CMD_CLEAR, rand_coord(), rand_coord());
        for (int i = 0; i < 259; i++)
          send_beat(npse_pkg::CMD_APPEND, rand_coord(), rand_coord());
        send_beat(npse_pkg::CMD_QUERY, rand_coord(), rand_coord());
        send_beat(npse_pkg::CMD_NONE, rand_coord(), rand_coord());
        send_beat(npse_pkg::CMD_QUERY, rand_coord(), rand_coord());
        send_beat(npse_pkg::CMD_CLEAR, rand_coord(), rand_coord());
      end
      if (p == 3) begin
        // result side holds off while lookups keep coming
        for (int i = 0; i < 4; i++)
          send_beat(npse_pkg::CMD_APPEND, rand_coord(), rand_coord());
        hold_asks++;
        for (int i = 0; i < 8; i++)
          send_beat(npse_pkg::CMD_QUERY, rand_coord(), rand_coord());
      end
      while (items_sent < phase_end) run_sequence();
    end

    wait_idle();
    repeat (50) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/npse_pkg.sv
rtl/npse_point_mem.sv
rtl/npse_sq_dist.sv
rtl/nearest_point_search_excluding_ends.sv
test/npse_result_check.sv
test/nearest_point_search_excluding_ends_tb.sv
